### rtl/aes_pkg.sv
package aes_pkg;

    localparam int NUM_ROUNDS_DEFAULT = 10;
    localparam int BLOCK_W = 128;

    typedef logic [BLOCK_W-1:0] block_t;

    // Forward S-box: GF(2^8) inverse followed by the affine map
    localparam logic [7:0] SBOX_TABLE [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] GF_POLY = 8'h1b;

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TABLE[b];
    endfunction

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // SubBytes and ShiftRows together; byte i sits at column i/4, row i%4
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(4*c+r) +: 8] = sbox(s[8*(4*((c+r) & 3)+r) +: 8]);
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a [4];
        logic [7:0] all;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = s[8*(4*c+r) +: 8];
            end
            all = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++) begin
                t[8*(4*c+r) +: 8] = a[r] ^ all ^ xtime(a[r] ^ a[(r+1) & 3]);
            end
        end
        return t;
    endfunction

endpackage

### rtl/aes_key_store.sv
module aes_key_store
    import aes_pkg::*;
#(
    parameter int DEPTH = NUM_ROUNDS_DEFAULT + 1,
    parameter int AW = $clog2(NUM_ROUNDS_DEFAULT + 1)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  block_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output block_t        rd_data
);

    block_t key_mem [DEPTH];
    block_t rd_data_reg;

    // Write one round key, read one with a registered output
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/aes_round.sv
module aes_round
    import aes_pkg::*;
(
    input  block_t state_in,
    input  block_t round_key,
    input  logic   last_round,
    output block_t keyed,
    output block_t round_out
);

    block_t shifted;

    // Add the round key, then substitute and shift; mix unless final round
    always_comb begin
        keyed     = state_in ^ round_key;
        shifted   = sub_shift(keyed);
        round_out = last_round ? shifted : mix_columns(shifted);
    end

endmodule

### rtl/aes128_block_encrypt_top.sv
// AES-128 block encryption engine with an externally expanded key.
//
// Input channel (s_valid/s_ready): s_op = 0 loads round key s_key_index
// (0 to NUM_ROUNDS) from {s_data_hi, s_data_lo}; an index above NUM_ROUNDS
// is dropped. s_op = 1 encrypts the block {s_data_hi, s_data_lo}, byte i at
// bits 8i. Result channel (m_valid/m_ready) carries the ciphertext in the
// same byte order; a load request gives no result.
//
// A load writes the key store directly. An encrypt request runs one round
// per cycle on a single shared round unit (key add, S-box, shift, mix),
// except that its final key add waits while the output register is busy.
// The next request is taken only once the ciphertext is in the output
// register and the sequencer is idle again. The round key for the next step
// is prefetched from the key store while idle and on each sequencer step.
//
// Reset clears the sequencer and the result valid; the key store is not
// cleared, so every round key must be loaded before the first encrypt.
// A stalled result holds in the output register; a new request is still
// taken, and its final round waits until the output register is free.
module aes128_block_encrypt_top
    import aes_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_data_lo,
    input  logic [63:0] s_data_hi,
    input  logic [3:0]  s_key_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_cipher_lo,
    output logic [63:0] m_cipher_hi
);

    localparam int KEY_DEPTH = NUM_ROUNDS + 1;
    localparam int KEY_AW = $clog2(KEY_DEPTH);
    localparam logic [KEY_AW-1:0] LAST_ROUND = KEY_AW'(NUM_ROUNDS);
    localparam logic [KEY_AW-1:0] FINAL_MIXLESS = KEY_AW'(NUM_ROUNDS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [KEY_AW-1:0] round_reg, round_next;
    block_t            block_reg, block_next;
    block_t            cipher_reg, cipher_next;
    logic              m_valid_reg, m_valid_next;

    logic              key_wr_en;
    logic              key_rd_en;
    logic [KEY_AW-1:0] key_rd_addr;
    block_t            round_key;
    block_t            keyed;
    block_t            round_out;
    logic              advance;
    logic              out_free;
    logic              in_range;

    aes_key_store #(
        .DEPTH (KEY_DEPTH),
        .AW    (KEY_AW)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (s_key_index[KEY_AW-1:0]),
        .wr_data ({s_data_hi, s_data_lo}),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (round_key)
    );

    aes_round u_round (
        .state_in   (block_reg),
        .round_key  (round_key),
        .last_round (round_reg == FINAL_MIXLESS),
        .keyed      (keyed),
        .round_out  (round_out)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_range = (32'(s_key_index) <= 32'(NUM_ROUNDS));
    assign out_free = !m_valid_reg || m_ready;

    // Store a round key on an in-range load request
    assign key_wr_en = s_valid && s_ready && !s_op && in_range;

    // Sequence the rounds and hand the ciphertext to the output register
    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        block_next   = block_reg;
        cipher_next  = cipher_reg;
        m_valid_next = m_valid_reg && !m_ready;
        advance      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op) begin
                    state_next = ST_RUN;
                    round_next = '0;
                    block_next = {s_data_hi, s_data_lo};
                end
            end
            ST_RUN: begin
                if (round_reg != LAST_ROUND) begin
                    advance    = 1'b1;
                    block_next = round_out;
                    round_next = round_reg + KEY_AW'(1);
                end else if (out_free) begin
                    advance      = 1'b1;
                    cipher_next  = keyed;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Prefetch key 0 while idle and on the final step, the next round's key on earlier steps
    assign key_rd_en = (state_reg == ST_IDLE) || advance;
    assign key_rd_addr = (state_reg == ST_RUN && round_reg != LAST_ROUND)
                       ? round_reg + KEY_AW'(1) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
        end
        block_reg  <= block_next;
        cipher_reg <= cipher_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_cipher_lo = cipher_reg[63:0];
    assign m_cipher_hi = cipher_reg[127:64];

    // An encrypt request starts the sequencer at the first round
    a_encrypt_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> state_reg == ST_RUN && round_reg == '0)
        else $error("encrypt request did not start the round sequence");

    // A load request leaves the sequencer idle
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_op |=> state_reg == ST_IDLE && !$rose(m_valid))
        else $error("load request disturbed the sequencer");

    // A result only appears at the end of the last round
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RUN && round_reg == LAST_ROUND))
        else $error("result raised outside the final round");

    // The round counter never runs past the last round
    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= LAST_ROUND)
        else $error("round counter out of range");

endmodule

### test/aes_tb_pkg.sv
package aes_tb_pkg;

    // Request kinds on the input channel
    typedef enum logic {
        OP_LOAD_KEY = 1'b0,
        OP_ENCRYPT  = 1'b1
    } aes_op_e;

    localparam int KEY_SLOTS = aes_pkg::NUM_ROUNDS_DEFAULT + 1;

endpackage

### test/aes128_cipher_checker.sv
module aes128_cipher_checker
    import aes_pkg::*;
    import aes_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_data_lo,
    input  logic [63:0] s_data_hi,
    input  logic [3:0]  s_key_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_cipher_lo,
    input  logic [63:0] m_cipher_hi,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUNDS = NUM_ROUNDS_DEFAULT;
    localparam logic [7:0] AFFINE_OFFSET = 8'h63;
    localparam logic [7:0] REDUCTION = 8'h1b;

    logic [7:0]   sbox_lut [256];
    logic [127:0] round_keys [KEY_SLOTS];
    logic [127:0] ciphertext_due [$];
    int           failures = 0;
    int           outstanding = 0;

    assign fail_count = failures;
    assign pending = outstanding;

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? REDUCTION : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] term;
        acc = '0;
        term = x;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                acc ^= term;
            end
            term = gf_double(term);
        end
        return acc;
    endfunction

    // Build the substitution table: field inverse (zero stays zero), then the affine map
    initial begin
        logic [7:0] inv;
        for (int v = 0; v < 256; v++) begin
            inv = '0;
            for (int w = 1; w < 256; w++) begin
                if (gf_product(8'(v), 8'(w)) == 8'h01) begin
                    inv = 8'(w);
                end
            end
            sbox_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_OFFSET;
        end
    end

    // Full cipher over the current key schedule; byte i of the block sits at bits 8i
    function automatic logic [127:0] encipher(input logic [127:0] plain);
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] rk;
        logic [127:0] ct;
        rk = round_keys[0];
        for (int i = 0; i < 16; i++) begin
            st[i] = plain[8*i +: 8] ^ rk[8*i +: 8];
        end
        for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
            // substitute, and take row r of column c from column c + r
            for (int i = 0; i < 16; i++) begin
                sh[i] = sbox_lut[st[(i + 4 * (i % 4)) % 16]];
            end
            // mix each column, skipped on the last round
            if (rnd < ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sh[4*c];
                    a1 = sh[4*c+1];
                    a2 = sh[4*c+2];
                    a3 = sh[4*c+3];
                    sh[4*c]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    sh[4*c+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    sh[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    sh[4*c+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end
            end
            rk = round_keys[rnd];
            for (int i = 0; i < 16; i++) begin
                st[i] = sh[i] ^ rk[8*i +: 8];
            end
        end
        for (int i = 0; i < 16; i++) begin
            ct[8*i +: 8] = st[i];
        end
        return ct;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        failures++;
    endtask

    // Retire results before taking new requests, so a stray result is never paired
    // with a request accepted on the same edge
    always @(posedge aclk) begin
        logic [127:0] due;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (ciphertext_due.size() == 0) begin
                    flag_mismatch($sformatf("result %h_%h with no encrypt request waiting",
                                            m_cipher_hi, m_cipher_lo));
                end else begin
                    due = ciphertext_due.pop_front();
                    if (m_cipher_lo !== due[63:0]) begin
                        flag_mismatch($sformatf("cipher_lo %h, expected %h",
                                                m_cipher_lo, due[63:0]));
                    end
                    if (m_cipher_hi !== due[127:64]) begin
                        flag_mismatch($sformatf("cipher_hi %h, expected %h",
                                                m_cipher_hi, due[127:64]));
                    end
                end
            end
            // Predict the request just accepted; drop key loads beyond the last round
            if (s_valid && s_ready) begin
                if (s_op == OP_ENCRYPT) begin
                    ciphertext_due.push_back(encipher({s_data_hi, s_data_lo}));
                end else if (s_key_index <= ROUNDS) begin
                    round_keys[s_key_index] = {s_data_hi, s_data_lo};
                end
            end
            outstanding = ciphertext_due.size();
        end
    end

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;
    import aes_tb_pkg::*;

    localparam int ITEM_TARGET = 1200;
    localparam int GAP_LIMIT = 18;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT_RESULT = 300;
    localparam int DRAIN_CYCLES = NUM_ROUNDS_DEFAULT + 8;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [63:0] s_data_lo;
    logic [63:0] s_data_hi;
    logic [3:0]  s_key_index;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_cipher_lo;
    logic [63:0] m_cipher_hi;
    int          fail_count;
    int          pending;
    int          send_gap_max = GAP_LIMIT;
    int          recv_gap_max = GAP_LIMIT;
    int          results_taken = 0;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    aes128_block_encrypt_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_lo   (s_data_lo),
        .s_data_hi   (s_data_hi),
        .s_key_index (s_key_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cipher_lo (m_cipher_lo),
        .m_cipher_hi (m_cipher_hi)
    );

    aes128_cipher_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_lo   (s_data_lo),
        .s_data_hi   (s_data_hi),
        .s_key_index (s_key_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cipher_lo (m_cipher_lo),
        .m_cipher_hi (m_cipher_hi),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Mostly random halves, now and then all zeros or all ones
    function automatic logic [63:0] rand_half();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one request after a random gap and hold it until accepted; starts and
    // ends just after a falling edge
    task automatic offer_request(input aes_op_e op, input logic [63:0] lo,
                                 input logic [63:0] hi, input logic [3:0] idx);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_data_lo   <= lo;
        s_data_hi   <= hi;
        s_key_index <= idx;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Load a complete fresh key schedule
    task automatic load_schedule();
        for (int k = 0; k < KEY_SLOTS; k++) begin
            offer_request(OP_LOAD_KEY, rand_half(), rand_half(), 4'(k));
        end
    endtask

    // Request stream
    initial begin
        int roll;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = OP_LOAD_KEY;
        s_data_lo   = '0;
        s_data_hi   = '0;
        s_key_index = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill every key slot, first and last at the extremes
        offer_request(OP_LOAD_KEY, '0, '0, 4'd0);
        for (int k = 1; k < NUM_ROUNDS_DEFAULT; k++) begin
            offer_request(OP_LOAD_KEY, {$urandom, $urandom}, {$urandom, $urandom}, 4'(k));
        end
        offer_request(OP_LOAD_KEY, '1, '1, 4'(NUM_ROUNDS_DEFAULT));
        // Loads past the last round must leave the schedule alone
        offer_request(OP_LOAD_KEY, '1, '1, 4'(NUM_ROUNDS_DEFAULT + 1));
        offer_request(OP_LOAD_KEY, '1, '1, 4'hf);
        // Extreme and patterned blocks
        offer_request(OP_ENCRYPT, '0, '0, 4'h0);
        offer_request(OP_ENCRYPT, '1, '1, 4'hf);
        offer_request(OP_ENCRYPT, {8{8'h80}}, {8{8'h01}}, 4'h5);
        offer_request(OP_ENCRYPT, {8{8'h55}}, {8{8'haa}}, 4'ha);
        // Replace one key between encrypts
        offer_request(OP_LOAD_KEY, '1, '0, 4'd0);
        offer_request(OP_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom}, 4'h0);
        offer_request(OP_ENCRYPT, '0, '1, 4'h3);

        for (int sent = 0; sent < ITEM_TARGET; sent++) begin
            // Switch between idling and back-to-back phases
            if (sent % 100 == 0) begin
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_LIMIT;
            end
            // Pause once until every outstanding ciphertext has come back
            if (sent == ITEM_TARGET / 2) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending != 0);
            end
            if (sent % 250 == 125) begin
                load_schedule();
            end
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
                offer_request(OP_ENCRYPT, rand_half(), rand_half(), 4'($urandom));
            end else if (roll < 94) begin
                offer_request(OP_LOAD_KEY, rand_half(), rand_half(),
                              4'($urandom_range(0, NUM_ROUNDS_DEFAULT)));
            end else begin
                offer_request(OP_LOAD_KEY, rand_half(), rand_half(),
                              4'($urandom_range(NUM_ROUNDS_DEFAULT + 1, 15)));
            end
        end

        // Drain, allow for any late extra result, then give the verdict
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("aes128_block_encrypt_top regression: pass");
        end else begin
            $display("aes128_block_encrypt_top regression: fail");
        end
        $finish;
    end

    // Result side: random back-pressure, with one long hold-off to fill the engine
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (results_taken % 60 == 0) begin
                recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_LIMIT;
            end
            if (results_taken == HOLD_AT_RESULT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
            @(negedge aclk);
        end
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("aes128_block_encrypt_top regression: fail");
        $finish;
    end

endmodule
